// ===== hdl/wph_pkg.sv =====
// Package for the waypoint heading steering core: sizes, codes, the state type
// and the constant tables for the CORDIC step angles and the heading scale.
// No dependencies; used by the core and its checker.
package wph_pkg;

  // Table and angle sizes.
  localparam int MAX_WAYPOINTS = 64;
  localparam int ANGLE_BITS    = 16;
  localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
  localparam int SLOT_LIMIT    = (MAX_WAYPOINTS < 64) ? MAX_WAYPOINTS : 64;

  // CORDIC datapath: 9-bit signed differences scaled by 2^24, plus growth headroom.
  localparam int COORD_SHIFT = 24;
  localparam int CW          = 9 + COORD_SHIFT + 3;
  localparam int ITER_W      = $clog2(ANGLE_BITS);

  // Tolerance conversion from 1/65536 turn to angle units.
  localparam int TOL_UP = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int TOL_DN = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
  localparam int TOL_W  = ANGLE_BITS + 16;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  localparam angle_t ANGLE_HALF = angle_t'(1) << (ANGLE_BITS - 1);

  // Request codes.
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_POSITION = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PATH_LENGTH     = 2'd0;
  localparam logic [1:0] CFG_ARRIVE_LIMIT_SQ = 2'd1;
  localparam logic [1:0] CFG_AWAY_TOLERANCE  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIST,
    ST_ITER,
    ST_STEER
  } state_t;

  // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32.
  localparam logic [31:0] ATAN_TURN32 [25] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028
  };

  typedef angle_t step_lut_t [ANGLE_BITS];
  typedef angle_t head_lut_t [256];

  // Step angles rounded to the angle width.
  function automatic step_lut_t build_step_lut();
    step_lut_t       lut;
    longint unsigned t;
    for (int i = 0; i < ANGLE_BITS; i++) begin
      t      = longint'(ATAN_TURN32[i]);
      lut[i] = angle_t'((t + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS));
    end
    return lut;
  endfunction

  // Heading code to angle: round(code * 2^ANGLE_BITS / 255), modulo one turn.
  function automatic head_lut_t build_head_lut();
    head_lut_t       lut;
    longint unsigned c;
    for (int i = 0; i < 256; i++) begin
      c      = longint'(i);
      lut[i] = angle_t'(((c << ANGLE_BITS) + 64'd127) / 64'd255);
    end
    return lut;
  endfunction

  localparam step_lut_t STEP_LUT = build_step_lut();
  localparam head_lut_t HEAD_LUT = build_head_lut();

endpackage

// ===== hdl/wph_ram.sv =====
// Generic single-port RAM with one write or read address per cycle and a
// registered read. No dependencies.
module wph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read at the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/waypoint_heading_steering_core.sv =====
// Waypoint heading steering core: waypoint table, arrival test and an
// iterative CORDIC bearing with bang-bang steering. Depends on wph_pkg and wph_ram.
//
// Channel   Direction  Handshake               Payload
// request   in         start & !busy           command, load_index, load_x, load_y,
//                                              pos_x, pos_y, heading_code
// result    out        done (one cycle)        drive_forward, turn_left, turn_right,
//                                              arrived, target_index
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// A load request is taken with busy staying low; its result shows in the next cycle.
// A position request holds busy through the DIFF and DIST states on arrival, else
// also through the CORDIC passes in the ITER state, which share one shift and add
// unit, and through the STEER state; its result shows in the cycle busy falls.
// Reset is synchronous; the waypoint table is not cleared and holds whatever
// was last loaded. The result receiver cannot stall; each strobe lasts one cycle.
module waypoint_heading_steering_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [5:0]  load_index,
  input  logic [7:0]  load_x,
  input  logic [7:0]  load_y,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [7:0]  heading_code,
  output logic        done,
  output logic        drive_forward,
  output logic        turn_left,
  output logic        turn_right,
  output logic        arrived,
  output logic [5:0]  target_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  // Configuration registers.
  logic [6:0]  path_length;
  logic [17:0] arrive_limit_sq;
  logic [14:0] away_tolerance;

  // Sequencer and datapath registers.
  wph_pkg::state_t              state, state_next;
  logic [wph_pkg::ITER_W-1:0]   iter, iter_next;
  logic [5:0]                   current_index, current_index_next;
  logic signed [wph_pkg::CW-1:0] vx, vx_next, vy, vy_next;
  wph_pkg::angle_t              z, z_next;
  wph_pkg::angle_t              head, head_next;
  logic                         zero_vec, zero_vec_next;
  logic [7:0]                   pos_xq, pos_xq_next, pos_yq, pos_yq_next;
  logic signed [8:0]            dx, dx_next, dy, dy_next;
  logic                         done_next;
  logic                         drive_forward_next, turn_left_next, turn_right_next;
  logic                         arrived_next;
  logic [5:0]                   target_index_next;

  // Table port.
  logic                         ram_we;
  logic [wph_pkg::ADDR_W-1:0]   ram_addr;
  logic [15:0]                  ram_rdata;

  logic                         accept;
  logic [6:0]                   len_eff;
  logic [5:0]                   idx_use;
  logic [5:0]                   idx_adv;
  logic                         slot_ok;
  logic signed [17:0]           sq_x, sq_y;
  logic [18:0]                  dist2;
  logic signed [wph_pkg::CW-1:0] shx, shy;
  logic signed [wph_pkg::CW-1:0] ix, iy;
  wph_pkg::angle_t              bear, delta, mag, gap;
  logic                         positive;
  logic [wph_pkg::TOL_W-1:0]    tol;

  assign accept    = start && !busy;
  assign busy      = (state != wph_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Effective path length: zero acts as one, clipped to the table size.
  always_comb begin
    if (path_length == 7'd0) begin
      len_eff = 7'd1;
    end else if (path_length > 7'(wph_pkg::SLOT_LIMIT)) begin
      len_eff = 7'(wph_pkg::SLOT_LIMIT);
    end else begin
      len_eff = path_length;
    end
  end

  // Index wrap on entry and advance on arrival.
  assign idx_use = ({1'b0, current_index} >= len_eff) ? 6'd0 : current_index;
  assign idx_adv = (({1'b0, current_index} + 7'd1) >= len_eff) ? 6'd0
                                                              : current_index + 6'd1;
  assign slot_ok = ({1'b0, load_index} < 7'(wph_pkg::SLOT_LIMIT));

  // Table access: a load writes its slot, a position request reads its waypoint.
  assign ram_we   = accept && (command == wph_pkg::CMD_LOAD) && slot_ok;
  assign ram_addr = (command == wph_pkg::CMD_LOAD) ? wph_pkg::ADDR_W'(load_index)
                                                   : wph_pkg::ADDR_W'(idx_use);

  wph_ram #(
    .WIDTH (16),
    .DEPTH (wph_pkg::MAX_WAYPOINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({load_y, load_x}),
    .rdata (ram_rdata)
  );

  // Squared distance.
  assign sq_x  = dx * dx;
  assign sq_y  = dy * dy;
  assign dist2 = 19'(unsigned'(sq_x)) + 19'(unsigned'(sq_y));

  // Shared CORDIC shift unit.
  assign shx = vx >>> iter;
  assign shy = vy >>> iter;

  // Initial vector: (dy north, dx east), turned a half turn when dy is negative.
  assign ix = wph_pkg::CW'(dy) <<< wph_pkg::COORD_SHIFT;
  assign iy = wph_pkg::CW'(dx) <<< wph_pkg::COORD_SHIFT;

  // Heading difference wrapped to a half turn either way.
  assign bear     = zero_vec ? '0 : z;
  assign delta    = bear - head;
  assign mag      = (delta >= wph_pkg::ANGLE_HALF) ? (~delta + 1'b1) : delta;
  assign positive = (delta < wph_pkg::ANGLE_HALF) && (delta != '0);
  assign gap      = wph_pkg::ANGLE_HALF - mag;
  assign tol      = (wph_pkg::TOL_W'(away_tolerance) << wph_pkg::TOL_UP) >> wph_pkg::TOL_DN;

  // Sequencer next state and datapath updates.
  always_comb begin
    state_next         = state;
    iter_next          = iter;
    current_index_next = current_index;
    vx_next            = vx;
    vy_next            = vy;
    z_next             = z;
    head_next          = head;
    zero_vec_next      = zero_vec;
    pos_xq_next        = pos_xq;
    pos_yq_next        = pos_yq;
    dx_next            = dx;
    dy_next            = dy;
    done_next          = 1'b0;
    drive_forward_next = drive_forward;
    turn_left_next     = turn_left;
    turn_right_next    = turn_right;
    arrived_next       = arrived;
    target_index_next  = target_index;
    unique case (state)
      wph_pkg::ST_IDLE: begin
        if (accept) begin
          if (command == wph_pkg::CMD_LOAD) begin
            done_next          = 1'b1;
            drive_forward_next = 1'b0;
            turn_left_next     = 1'b0;
            turn_right_next    = 1'b0;
            arrived_next       = 1'b0;
            target_index_next  = current_index;
          end else begin
            current_index_next = idx_use;
            pos_xq_next        = pos_x;
            pos_yq_next        = pos_y;
            head_next          = wph_pkg::HEAD_LUT[heading_code];
            state_next         = wph_pkg::ST_DIFF;
          end
        end
      end
      wph_pkg::ST_DIFF: begin
        dx_next    = $signed({1'b0, ram_rdata[7:0]}) - $signed({1'b0, pos_xq});
        dy_next    = $signed({1'b0, ram_rdata[15:8]}) - $signed({1'b0, pos_yq});
        state_next = wph_pkg::ST_DIST;
      end
      wph_pkg::ST_DIST: begin
        if (dist2 < {1'b0, arrive_limit_sq}) begin
          current_index_next = idx_adv;
          done_next          = 1'b1;
          drive_forward_next = 1'b0;
          turn_left_next     = 1'b0;
          turn_right_next    = 1'b0;
          arrived_next       = 1'b1;
          target_index_next  = idx_adv;
          state_next         = wph_pkg::ST_IDLE;
        end else begin
          zero_vec_next = (dx == 9'sd0) && (dy == 9'sd0);
          if (dy < 9'sd0) begin
            vx_next = -ix;
            vy_next = -iy;
            z_next  = wph_pkg::ANGLE_HALF;
          end else begin
            vx_next = ix;
            vy_next = iy;
            z_next  = '0;
          end
          iter_next  = '0;
          state_next = wph_pkg::ST_ITER;
        end
      end
      wph_pkg::ST_ITER: begin
        // One rotation step toward the positive x axis.
        if (vy >= 0) begin
          vx_next = vx + shy;
          vy_next = vy - shx;
          z_next  = z + wph_pkg::STEP_LUT[iter];
        end else begin
          vx_next = vx - shy;
          vy_next = vy + shx;
          z_next  = z - wph_pkg::STEP_LUT[iter];
        end
        iter_next = iter + 1'b1;
        if (iter == wph_pkg::ITER_W'(wph_pkg::ANGLE_BITS - 1)) begin
          state_next = wph_pkg::ST_STEER;
        end
      end
      wph_pkg::ST_STEER: begin
        done_next          = 1'b1;
        drive_forward_next = 1'b1;
        arrived_next       = 1'b0;
        target_index_next  = current_index;
        if (wph_pkg::TOL_W'(gap) < tol) begin
          turn_left_next  = 1'b0;
          turn_right_next = 1'b0;
        end else begin
          turn_left_next  = !positive;
          turn_right_next = positive;
        end
        state_next = wph_pkg::ST_IDLE;
      end
      default: begin
        state_next = wph_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wph_pkg::ST_IDLE;
      done          <= 1'b0;
      current_index <= 6'd0;
    end else begin
      state         <= state_next;
      done          <= done_next;
      current_index <= current_index_next;
    end
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      path_length     <= 7'd1;
      arrive_limit_sq <= 18'd1;
      away_tolerance  <= 15'd2503;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wph_pkg::CFG_PATH_LENGTH:     path_length     <= cfg_data[6:0];
        wph_pkg::CFG_ARRIVE_LIMIT_SQ: arrive_limit_sq <= cfg_data;
        wph_pkg::CFG_AWAY_TOLERANCE:  away_tolerance  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    iter          <= iter_next;
    vx            <= vx_next;
    vy            <= vy_next;
    z             <= z_next;
    head          <= head_next;
    zero_vec      <= zero_vec_next;
    pos_xq        <= pos_xq_next;
    pos_yq        <= pos_yq_next;
    dx            <= dx_next;
    dy            <= dy_next;
    drive_forward <= drive_forward_next;
    turn_left     <= turn_left_next;
    turn_right    <= turn_right_next;
    arrived       <= arrived_next;
    target_index  <= target_index_next;
  end

endmodule

// ===== hdl/wph_checker.sv =====
// Port-level checker for the waypoint heading steering core and its bind.
// Depends on wph_pkg and waypoint_heading_steering_core.
module wph_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       command,
  input logic       done,
  input logic       drive_forward,
  input logic       turn_left,
  input logic       turn_right,
  input logic       arrived
);

  // A result never shows while a position request is still at work.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // A result carries at most one of left, right and arrival.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({turn_left, turn_right, arrived}))
    else $error("conflicting result flags");

  // Arrival releases the forward drive; a turn always comes with it.
  assert property (@(posedge clk) disable iff (rst)
    done && (arrived || turn_left || turn_right) |-> (drive_forward == !arrived))
    else $error("forward drive inconsistent with result");

  // A load request answers in the next cycle with every drive released.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == wph_pkg::CMD_LOAD) |=>
      done && !drive_forward && !arrived && !turn_left && !turn_right)
    else $error("load result missing or wrong");

  // A position request makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == wph_pkg::CMD_POSITION) |=> busy && !done)
    else $error("position request not taken up");

endmodule

bind waypoint_heading_steering_core wph_checker u_wph_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .command       (command),
  .done          (done),
  .drive_forward (drive_forward),
  .turn_left     (turn_left),
  .turn_right    (turn_right),
  .arrived       (arrived)
);
